// File: rtl/fermat_factoriser_macros.svh
// Assertion macros used by the fermat_factoriser RTL.
`ifndef FERMAT_FACTORISER_MACROS_SVH
`define FERMAT_FACTORISER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define FF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define FF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FF_ASSERT_IMP(label, ante, cons, msg)
`define FF_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/ferfac_pkg.sv
// Package with the widths and constants of the Fermat factoriser.
`default_nettype none
package ferfac_pkg;

  // Width of the modulus bits that take part in the search.
  localparam int MOD_WIDTH = 32;
  // Port widths fixed by the interface.
  localparam int IN_W    = 32;
  localparam int OUT_W   = 32;
  localparam int LIMIT_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'h8000_0000;

  // Serial datapath: one digit of DIGIT_W bits per cycle.
  localparam int DIGIT_W   = 4;
  // Working word: y can climb to the full limit, x and the residue need some headroom.
  localparam int WORD_W    = ((LIMIT_W + 4 + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam int NDIG      = WORD_W / DIGIT_W;
  localparam int DIG_CNT_W = $clog2(NDIG);

  // The square root consumes two modulus bits per iteration.
  localparam int SQ_W      = MOD_WIDTH + (MOD_WIDTH % 2);
  localparam int SQ_ITERS  = SQ_W / 2;
  localparam int SQ_CNT_W  = $clog2(SQ_ITERS);

endpackage
`default_nettype wire

// File: rtl/fermat_factoriser.sv
// Fermat factoriser top level: digit-serial integer root and Fermat search.
//
// Takes one modulus word n and returns one result word: the factor pair (x+y, x-y)
// for the smallest y with n + y*y a perfect square x*x, or status 1 with zero
// factors when trial_limit values of y have gone by without a square. Everything
// runs through one 4-bit serial adder slice over 36-bit shift registers, so every
// arithmetic pass walks the word digit by digit after one setup or decision state.
// An item first takes the exact integer square root of n (16 passes), then one
// pass per search step, where a step advances either x or y by one, and finally
// one pass to form the two factors: x_end - floor(sqrt(n)) + y_end search steps
// in all, so the time depends strongly on the data. A modulus that is two
// mod four never hits a square and runs until y reaches trial_limit. One word is in
// flight at a time; a new word is taken while the previous result waits at the
// output register.
`default_nettype none
`include "fermat_factoriser_macros.svh"
module fermat_factoriser (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ferfac_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [ferfac_pkg::IN_W-1:0]      in_modulus,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [ferfac_pkg::OUT_W-1:0]     out_factor_high,
  output      logic [ferfac_pkg::OUT_W-1:0]     out_factor_low,
  output      logic                             out_status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_PREP,
    ST_PASS,
    ST_DECIDE,
    ST_DONE
  } state_t;

  // What a serial pass computes.
  typedef enum logic [1:0] {
    OP_SQRT,   // r - (4x + 1): trial subtract of the root
    OP_XSTEP,  // r - (2x + 1), x + 1
    OP_YSTEP,  // r + (2y + 1), y + 1, t - 1
    OP_OUT     // x + y and x - y
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt, op_sel;

  logic [ferfac_pkg::LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [ferfac_pkg::DIG_CNT_W-1:0] dig_cnt_r, dig_cnt_nxt;
  logic [ferfac_pkg::SQ_CNT_W-1:0]  sq_cnt_r, sq_cnt_nxt;

  // r = n + y*y - x*x, t = trials left; during a pass all rotate one digit per cycle.
  logic [ferfac_pkg::WORD_W-1:0] r_r, r_nxt;
  logic [ferfac_pkg::WORD_W-1:0] x_r, x_nxt;
  logic [ferfac_pkg::WORD_W-1:0] y_r, y_nxt;
  logic [ferfac_pkg::WORD_W-1:0] t_r, t_nxt;
  logic [ferfac_pkg::WORD_W-1:0] d_r, d_nxt;
  logic [ferfac_pkg::WORD_W-1:0] e_r, e_nxt;
  logic [ferfac_pkg::SQ_W-1:0]   n_r, n_nxt;

  logic r_zero_r, r_zero_nxt;
  logic r_neg_r, r_neg_nxt;
  logic tz_r, tz_nxt;
  logic found_r, found_nxt;
  logic zacc_r, zacc_nxt;
  logic tzacc_r, tzacc_nxt;
  logic c_main_r, c_main_nxt;
  logic c_aux_r, c_aux_nxt;
  logic c_t_r, c_t_nxt;
  logic [1:0] pv_r, pv_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [ferfac_pkg::OUT_W-1:0]   out_factor_high_r, out_factor_high_nxt;
  logic [ferfac_pkg::OUT_W-1:0]   out_factor_low_r, out_factor_low_nxt;
  logic                           out_status_r, out_status_nxt;

  // Digit slice.
  logic [ferfac_pkg::DIGIT_W-1:0] rd, xd, yd, td, bsel, opd;
  logic [ferfac_pkg::DIGIT_W-1:0] a_main, b_main, sum_d;
  logic [ferfac_pkg::DIGIT_W-1:0] a_aux, b_aux, aux_d, t_d;
  logic [ferfac_pkg::DIGIT_W+1:0] ext;
  logic                           c_main_o, c_aux_o, c_t_o;
  logic                           last_dig, sum_neg, sum_zero;
  logic [1:0]                     top2;
  logic [ferfac_pkg::WORD_W-1:0]  full_sum, x_orig;

  assign rd   = r_r[ferfac_pkg::DIGIT_W-1:0];
  assign xd   = x_r[ferfac_pkg::DIGIT_W-1:0];
  assign yd   = y_r[ferfac_pkg::DIGIT_W-1:0];
  assign td   = t_r[ferfac_pkg::DIGIT_W-1:0];
  assign bsel = (op_r == OP_YSTEP) ? yd : xd;

  // The operand 2b+1 or 4b+1 is formed on the fly from the carried-over top bits.
  assign ext = {bsel, pv_r};
  assign opd = (op_r == OP_SQRT) ? ext[ferfac_pkg::DIGIT_W-1:0]
                                 : ext[ferfac_pkg::DIGIT_W:1];

  always_comb begin
    a_main = rd;
    b_main = ~opd;
    a_aux  = xd;
    b_aux  = '0;
    unique case (op_r) inside
      OP_SQRT, OP_XSTEP: begin
        b_main = ~opd;
      end
      OP_YSTEP: begin
        b_main = opd;
        a_aux  = yd;
      end
      OP_OUT: begin
        a_main = xd;
        b_main = yd;
        b_aux  = ~yd;
      end
      default: begin
        b_main = ~opd;
      end
    endcase
  end

  assign {c_main_o, sum_d} = {1'b0, a_main} + {1'b0, b_main}
                             + {{ferfac_pkg::DIGIT_W{1'b0}}, c_main_r};
  assign {c_aux_o, aux_d}  = {1'b0, a_aux} + {1'b0, b_aux}
                             + {{ferfac_pkg::DIGIT_W{1'b0}}, c_aux_r};
  assign {c_t_o, t_d}      = {1'b0, td} + {1'b0, {ferfac_pkg::DIGIT_W{1'b1}}}
                             + {{ferfac_pkg::DIGIT_W{1'b0}}, c_t_r};

  assign last_dig = (dig_cnt_r == ferfac_pkg::DIG_CNT_W'(ferfac_pkg::NDIG - 1));
  assign sum_neg  = sum_d[ferfac_pkg::DIGIT_W-1];
  assign sum_zero = !(zacc_r || (|sum_d));
  assign full_sum = {sum_d, d_r[ferfac_pkg::WORD_W-1:ferfac_pkg::DIGIT_W]};
  assign x_orig   = {xd, x_r[ferfac_pkg::WORD_W-1:ferfac_pkg::DIGIT_W]};
  assign top2     = n_r[ferfac_pkg::SQ_W-1 -: 2];

  always_comb begin
    state_nxt           = state_r;
    op_nxt              = op_r;
    op_sel              = OP_OUT;
    limit_nxt           = cfg_we ? cfg_wdata : limit_r;
    dig_cnt_nxt         = dig_cnt_r;
    sq_cnt_nxt          = sq_cnt_r;
    r_nxt               = r_r;
    x_nxt               = x_r;
    y_nxt               = y_r;
    t_nxt               = t_r;
    d_nxt               = d_r;
    e_nxt               = e_r;
    n_nxt               = n_r;
    r_zero_nxt          = r_zero_r;
    r_neg_nxt           = r_neg_r;
    tz_nxt              = tz_r;
    found_nxt           = found_r;
    zacc_nxt            = zacc_r;
    tzacc_nxt           = tzacc_r;
    c_main_nxt          = c_main_r;
    c_aux_nxt           = c_aux_r;
    c_t_nxt             = c_t_r;
    pv_nxt              = pv_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_factor_high_nxt = out_factor_high_r;
    out_factor_low_nxt  = out_factor_low_r;
    out_status_nxt      = out_status_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt      = ferfac_pkg::SQ_W'(in_modulus[ferfac_pkg::MOD_WIDTH-1:0]);
          r_nxt      = '0;
          x_nxt      = '0;
          y_nxt      = '0;
          t_nxt      = ferfac_pkg::WORD_W'(limit_r);
          r_zero_nxt = 1'b1;
          r_neg_nxt  = 1'b0;
          tz_nxt     = (limit_r == '0);
          sq_cnt_nxt = '0;
          state_nxt  = ST_SQ_PREP;
        end
      end

      ST_SQ_PREP: begin
        // Bring down the next two bits of n into the partial remainder.
        r_nxt       = {r_r[ferfac_pkg::WORD_W-3:0], top2};
        n_nxt       = {n_r[ferfac_pkg::SQ_W-3:0], 2'b00};
        r_zero_nxt  = r_zero_r && (top2 == 2'b00);
        op_nxt      = OP_SQRT;
        c_main_nxt  = 1'b1;
        c_aux_nxt   = 1'b1;
        c_t_nxt     = 1'b0;
        pv_nxt      = 2'b01;
        zacc_nxt    = 1'b0;
        tzacc_nxt   = 1'b0;
        dig_cnt_nxt = '0;
        state_nxt   = ST_PASS;
      end

      ST_DECIDE: begin
        // The trial budget is checked before the square test: y must stay below it.
        if (tz_r) begin
          found_nxt = 1'b0;
          op_sel    = OP_OUT;
        end else if (r_zero_r) begin
          found_nxt = 1'b1;
          op_sel    = OP_OUT;
        end else if (r_neg_r) begin
          op_sel    = OP_YSTEP;
        end else begin
          op_sel    = OP_XSTEP;
        end
        op_nxt      = op_sel;
        c_main_nxt  = (op_sel == OP_XSTEP);
        c_aux_nxt   = 1'b1;
        c_t_nxt     = 1'b0;
        pv_nxt      = 2'b10;
        zacc_nxt    = 1'b0;
        tzacc_nxt   = 1'b0;
        dig_cnt_nxt = '0;
        state_nxt   = ST_PASS;
      end

      ST_PASS: begin
        r_nxt = {rd, r_r[ferfac_pkg::WORD_W-1:ferfac_pkg::DIGIT_W]};
        d_nxt = full_sum;
        e_nxt = {aux_d, e_r[ferfac_pkg::WORD_W-1:ferfac_pkg::DIGIT_W]};
        x_nxt = {(op_r == OP_XSTEP) ? aux_d : xd,
                 x_r[ferfac_pkg::WORD_W-1:ferfac_pkg::DIGIT_W]};
        y_nxt = {(op_r == OP_YSTEP) ? aux_d : yd,
                 y_r[ferfac_pkg::WORD_W-1:ferfac_pkg::DIGIT_W]};
        t_nxt = {(op_r == OP_YSTEP) ? t_d : td,
                 t_r[ferfac_pkg::WORD_W-1:ferfac_pkg::DIGIT_W]};
        c_main_nxt  = c_main_o;
        c_aux_nxt   = c_aux_o;
        c_t_nxt     = c_t_o;
        pv_nxt      = bsel[ferfac_pkg::DIGIT_W-1 -: 2];
        zacc_nxt    = !sum_zero;
        tzacc_nxt   = tzacc_r || (|t_d);
        dig_cnt_nxt = dig_cnt_r + ferfac_pkg::DIG_CNT_W'(1);

        if (last_dig) begin
          unique case (op_r) inside
            OP_SQRT: begin
              // Keep the difference only when the trial fitted; the root gains one bit.
              if (!sum_neg) begin
                r_nxt      = full_sum;
                r_zero_nxt = sum_zero;
              end
              x_nxt      = {x_orig[ferfac_pkg::WORD_W-2:0], !sum_neg};
              sq_cnt_nxt = sq_cnt_r + ferfac_pkg::SQ_CNT_W'(1);
              if (sq_cnt_r == ferfac_pkg::SQ_CNT_W'(ferfac_pkg::SQ_ITERS - 1)) begin
                state_nxt = ST_DECIDE;
              end else begin
                state_nxt = ST_SQ_PREP;
              end
            end
            OP_XSTEP, OP_YSTEP: begin
              r_nxt      = full_sum;
              r_zero_nxt = sum_zero;
              r_neg_nxt  = sum_neg;
              if (op_r == OP_YSTEP) begin
                tz_nxt = !(tzacc_r || (|t_d));
              end
              state_nxt = ST_DECIDE;
            end
            OP_OUT: begin
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DECIDE;
            end
          endcase
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_factor_high_nxt = found_r ? d_r[ferfac_pkg::OUT_W-1:0] : '0;
          out_factor_low_nxt  = found_r ? e_r[ferfac_pkg::OUT_W-1:0] : '0;
          out_status_nxt      = !found_r;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_SQRT;
      limit_r     <= ferfac_pkg::LIMIT_RESET;
      dig_cnt_r   <= '0;
      sq_cnt_r    <= '0;
      r_neg_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      op_r              <= op_nxt;
      limit_r           <= limit_nxt;
      dig_cnt_r         <= dig_cnt_nxt;
      sq_cnt_r          <= sq_cnt_nxt;
      r_neg_r           <= r_neg_nxt;
      out_valid_r       <= out_valid_nxt;
      r_r               <= r_nxt;
      x_r               <= x_nxt;
      y_r               <= y_nxt;
      t_r               <= t_nxt;
      d_r               <= d_nxt;
      e_r               <= e_nxt;
      n_r               <= n_nxt;
      r_zero_r          <= r_zero_nxt;
      tz_r              <= tz_nxt;
      found_r           <= found_nxt;
      zacc_r            <= zacc_nxt;
      tzacc_r           <= tzacc_nxt;
      c_main_r          <= c_main_nxt;
      c_aux_r           <= c_aux_nxt;
      c_t_r             <= c_t_nxt;
      pv_r              <= pv_nxt;
      out_factor_high_r <= out_factor_high_nxt;
      out_factor_low_r  <= out_factor_low_nxt;
      out_status_r      <= out_status_nxt;
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_factor_high = out_factor_high_r;
  assign out_factor_low  = out_factor_low_r;
  assign out_status      = out_status_r;

  `FF_ASSERT_NXT(a_accept_starts_root, in_valid && in_ready, state_r == ST_SQ_PREP, "accepted word did not start the root")
  `FF_ASSERT_IMP(a_root_rem_nonneg, state_r == ST_SQ_PREP || (state_r == ST_PASS && op_r == OP_SQRT), !r_neg_r, "residue negative during the root")
  `FF_ASSERT_IMP(a_miss_is_zero, out_valid_r && out_status_r, out_factor_high_r == '0 && out_factor_low_r == '0, "miss result carries factors")
  `FF_ASSERT_IMP(a_found_order, out_valid_r && !out_status_r, out_factor_high_r >= out_factor_low_r, "factors out of order")

endmodule
`default_nettype wire
